// ===== rtl/core/fdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, codes and the CRC32 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOOT_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOOT_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY    = 3'd4;

	localparam logic [7:0]  RST_HEAD_FIRST  = 8'hAA;
	localparam logic [7:0]  RST_HEAD_SECOND = 8'h55;
	localparam logic [7:0]  RST_FOOT_FIRST  = 8'h55;
	localparam logic [7:0]  RST_FOOT_SECOND = 8'hAA;
	localparam logic [31:0] RST_CRC_POLY    = 32'hEDB88320;

	localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
	localparam logic [2:0] KIND_GOOD     = 3'd1;
	localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
	localparam logic [2:0] KIND_TOO_LONG = 3'd3;
	localparam logic [2:0] KIND_BAD_FOOT = 3'd4;

	localparam logic [10:0] LEN_SAT = 11'h7FF;

	typedef struct packed {
		logic [7:0]  head_first;
		logic [7:0]  head_second;
		logic [7:0]  foot_first;
		logic [7:0]  foot_second;
		logic [31:0] crc_poly;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [15:0] frame_seq;
		logic [15:0] frame_type;
		logic [10:0] frame_length;
	} rec_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
		input logic [7:0] data, input logic [31:0] poly);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ data};
		for (int b = 0; b < 8; b++) begin
			t = t[0] ? ((t >> 1) ^ poly) : (t >> 1);
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

	function automatic logic [10:0] sat_len(input logic [31:0] len);
		return (len > {21'd0, LEN_SAT}) ? LEN_SAT : len[10:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fdc_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_parse
// Frame parser: hunts the head, collects header fields, passes the payload
// and checks CRC and foot. One byte per step, result produced combinationally.
// ----------------------------------------------------------------------------
module fdc_parse import fdc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	output logic            rec_valid,
	output rec_t            rec
);

	localparam int          CNT_W   = $clog2(MAX_PAYLOAD + 1);
	localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);

	localparam logic [4:0] PH_HEAD0 = 5'd0;
	localparam logic [4:0] PH_HEAD1 = 5'd1;
	localparam logic [4:0] PH_SEQ0  = 5'd2;
	localparam logic [4:0] PH_SEQ1  = 5'd3;
	localparam logic [4:0] PH_TYPE0 = 5'd4;
	localparam logic [4:0] PH_TYPE1 = 5'd5;
	localparam logic [4:0] PH_LEN0  = 5'd6;
	localparam logic [4:0] PH_LEN1  = 5'd7;
	localparam logic [4:0] PH_LEN2  = 5'd8;
	localparam logic [4:0] PH_LEN3  = 5'd9;
	localparam logic [4:0] PH_DATA  = 5'd10;
	localparam logic [4:0] PH_CRC0  = 5'd11;
	localparam logic [4:0] PH_CRC1  = 5'd12;
	localparam logic [4:0] PH_CRC2  = 5'd13;
	localparam logic [4:0] PH_CRC3  = 5'd14;
	localparam logic [4:0] PH_FOOT0 = 5'd15;
	localparam logic [4:0] PH_FOOT1 = 5'd16;

	logic [4:0]       phase_q, phase_d;
	logic [15:0]      seq_q, seq_d;
	logic [15:0]      type_q, type_d;
	logic [31:0]      length_q, length_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [31:0]      crc_q, crc_d, crc_base, crc_new;
	logic [31:0]      rcrc_q, rcrc_d;
	logic [31:0]      len_new;
	logic             in_crc_span;

	always_comb begin
		phase_d   = phase_q;
		seq_d     = seq_q;
		type_d    = type_q;
		length_d  = length_q;
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		rcrc_d    = rcrc_q;
		rec_valid = 1'b0;
		rec       = '0;

		in_crc_span = (phase_q >= PH_HEAD1) && (phase_q <= PH_DATA);
		crc_base    = in_crc_span ? crc_q : 32'd0;
		crc_new     = crc32_byte(crc_base, in_byte, cfg.crc_poly);
		cnt_inc     = cnt_q + 1'b1;
		len_new     = {in_byte, length_q[23:0]};

		if (in_crc_span) begin
			crc_d = crc_new;
		end

		unique case (phase_q)
			PH_HEAD1: begin
				phase_d = (in_byte == cfg.head_second) ? PH_SEQ0 : PH_HEAD0;
			end
			PH_SEQ0: begin
				seq_d   = {8'd0, in_byte};
				phase_d = PH_SEQ1;
			end
			PH_SEQ1: begin
				seq_d   = {in_byte, seq_q[7:0]};
				phase_d = PH_TYPE0;
			end
			PH_TYPE0: begin
				type_d  = {8'd0, in_byte};
				phase_d = PH_TYPE1;
			end
			PH_TYPE1: begin
				type_d  = {in_byte, type_q[7:0]};
				phase_d = PH_LEN0;
			end
			PH_LEN0: begin
				length_d = {24'd0, in_byte};
				phase_d  = PH_LEN1;
			end
			PH_LEN1: begin
				length_d = {length_q[31:16], in_byte, length_q[7:0]};
				phase_d  = PH_LEN2;
			end
			PH_LEN2: begin
				length_d = {length_q[31:24], in_byte, length_q[15:0]};
				phase_d  = PH_LEN3;
			end
			PH_LEN3: begin
				length_d = len_new;
				cnt_d    = '0;
				if (len_new > MAX_LEN) begin
					phase_d   = PH_HEAD0;
					rec_valid = 1'b1;
					rec.kind         = KIND_TOO_LONG;
					rec.frame_seq    = seq_q;
					rec.frame_type   = type_q;
					rec.frame_length = sat_len(len_new);
				end else begin
					phase_d = (len_new == 32'd0) ? PH_CRC0 : PH_DATA;
				end
			end
			PH_DATA: begin
				cnt_d = cnt_inc;
				if (32'(cnt_inc) >= length_q) begin
					phase_d = PH_CRC0;
				end
				rec_valid        = 1'b1;
				rec.kind         = KIND_PAYLOAD;
				rec.payload_byte = in_byte;
			end
			PH_CRC0: begin
				rcrc_d  = {24'd0, in_byte};
				phase_d = PH_CRC1;
			end
			PH_CRC1: begin
				rcrc_d  = {rcrc_q[31:16], in_byte, rcrc_q[7:0]};
				phase_d = PH_CRC2;
			end
			PH_CRC2: begin
				rcrc_d  = {rcrc_q[31:24], in_byte, rcrc_q[15:0]};
				phase_d = PH_CRC3;
			end
			PH_CRC3: begin
				rcrc_d  = {in_byte, rcrc_q[23:0]};
				phase_d = PH_FOOT0;
			end
			PH_FOOT0: begin
				if (in_byte == cfg.foot_first) begin
					phase_d = PH_FOOT1;
				end else begin
					phase_d          = PH_HEAD0;
					rec_valid        = 1'b1;
					rec.kind         = KIND_BAD_FOOT;
					rec.frame_seq    = seq_q;
					rec.frame_type   = type_q;
					rec.frame_length = sat_len(length_q);
				end
			end
			PH_FOOT1: begin
				phase_d          = PH_HEAD0;
				rec_valid        = 1'b1;
				rec.frame_seq    = seq_q;
				rec.frame_type   = type_q;
				rec.frame_length = sat_len(length_q);
				if (in_byte != cfg.foot_second) begin
					rec.kind = KIND_BAD_FOOT;
				end else if (crc_q == rcrc_q) begin
					rec.kind = KIND_GOOD;
				end else begin
					rec.kind = KIND_CRC_ERR;
				end
			end
			default: begin
				if (in_byte == cfg.head_first) begin
					crc_d   = crc_new;
					phase_d = PH_HEAD1;
				end else begin
					phase_d = PH_HEAD0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD0;
			seq_q    <= '0;
			type_q   <= '0;
			length_q <= '0;
			cnt_q    <= '0;
			crc_q    <= '0;
			rcrc_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			seq_q    <= seq_d;
			type_q   <= type_d;
			length_q <= length_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			rcrc_q   <= rcrc_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/frame_deframer_crc32.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_deframer_crc32
// Byte-stream deframer with CRC32 check: configuration registers, frame
// parser and a registered result stage with a one-entry skid buffer.
// ----------------------------------------------------------------------------
// A result is registered in the output stage, or the skid entry on a stall.
// Throughput: one byte per cycle, set by the combinational CRC byte update
// and parser step. in_ready drops only while the skid entry is
// occupied. Asynchronous reset returns the parser to the head hunt, empties
// the result stage and loads the marker and polynomial registers defaults.
module frame_deframer_crc32 import fdc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            in_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 kind,
	output logic [7:0]                 payload_byte,
	output logic [15:0]                frame_seq,
	output logic [15:0]                frame_type,
	output logic [10:0]                frame_length
);

	cfg_t cfg_q;
	logic step;
	logic rec_valid;
	rec_t rec;
	logic out_valid_q, skid_valid_q, out_load;
	rec_t out_rec_q, skid_rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_first  <= RST_HEAD_FIRST;
			cfg_q.head_second <= RST_HEAD_SECOND;
			cfg_q.foot_first  <= RST_FOOT_FIRST;
			cfg_q.foot_second <= RST_FOOT_SECOND;
			cfg_q.crc_poly    <= RST_CRC_POLY;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HEAD_FIRST:  cfg_q.head_first  <= cfg_data[7:0];
				REG_HEAD_SECOND: cfg_q.head_second <= cfg_data[7:0];
				REG_FOOT_FIRST:  cfg_q.foot_first  <= cfg_data[7:0];
				REG_FOOT_SECOND: cfg_q.foot_second <= cfg_data[7:0];
				REG_CRC_POLY:    cfg_q.crc_poly    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_valid_q;
	assign step     = in_valid && in_ready;

	fdc_parse #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.in_byte   (in_byte),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	assign out_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || (step && rec_valid);
			skid_valid_q <= 1'b0;
		end else if (step && rec_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rec_q <= skid_valid_q ? skid_rec_q : rec;
		end
		if (!out_load && step && rec_valid) begin
			skid_rec_q <= rec;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_rec_q.kind;
	assign payload_byte = out_rec_q.payload_byte;
	assign frame_seq    = out_rec_q.frame_seq;
	assign frame_type   = out_rec_q.frame_type;
	assign frame_length = out_rec_q.frame_length;

endmodule
`default_nettype wire

// ===== rtl/core/fdc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fdc_checker import fdc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [7:0]  payload_byte,
	input wire logic [15:0] frame_seq,
	input wire logic [15:0] frame_type,
	input wire logic [10:0] frame_length
);

	localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind)
			&& $stable(payload_byte) && $stable(frame_seq)
			&& $stable(frame_type) && $stable(frame_length))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |->
			frame_seq == 16'd0 && frame_type == 16'd0 && frame_length == 11'd0)
		else $error("payload transfer carries frame fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
		else $error("end record carries a data byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TOO_LONG |->
			frame_length == LEN_SAT || {21'd0, frame_length} > MAX_LEN)
		else $error("oversize record with an acceptable length");

endmodule

bind frame_deframer_crc32 fdc_checker #(
	.MAX_PAYLOAD(MAX_PAYLOAD)
) u_fdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.payload_byte (payload_byte),
	.frame_seq    (frame_seq),
	.frame_type   (frame_type),
	.frame_length (frame_length)
);
`default_nettype wire
